// ===== hw/rtl/hdlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_pkg
// Shared types and constants for the NRZI decode / destuff deframer.
// ----------------------------------------------------------------------------
package hdlc_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [2:0]  OnesLimit         = 3'd5;
  localparam logic [3:0]  GoodSlot          = 4'd2;
  localparam logic [3:0]  SlotReset         = 4'd8;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_ABORT      = 2'd2,
    ST_NO_FLAG    = 2'd3
  } frame_status_e;

  typedef enum logic {
    REG_SKIP_FIRST = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
    logic       last_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]    data_byte;
    logic          is_status;
    frame_status_e status;
    logic          last_result;
  } rx_result_t;

  // Work for the back end produced by one input transaction.
  typedef struct packed {
    logic          has_data;
    logic [7:0]    data;
    logic          has_status;
    frame_status_e status;
  } hdlc_entry_t;

endpackage

// ===== hw/rtl/hdlc_fe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_fe
// Front end: NRZI decode, flag/abort detection and zero destuffing of one line
// byte per cycle when accepted; emits one queue entry per transaction with results.
// ----------------------------------------------------------------------------
module hdlc_fe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 skip_first_i,
  input  logic                 accept_i,
  input  hdlc_pkg::rx_item_t   item_i,
  output logic                 push_o,
  output hdlc_pkg::hdlc_entry_t entry_o
);
  import hdlc_pkg::*;

  typedef struct packed {
    logic       prev;
    logic [1:0] look;
    logic [1:0] fill;
    logic [2:0] ones;
    logic       drop;
    logic [7:0] pack;
    logic [3:0] slot;
    logic       skipping;
    logic       done;
  } fe_state_t;

  fe_state_t   state_q, state_d;
  hdlc_entry_t entry;

  localparam fe_state_t StateReset = '{
    prev: 1'b0, look: 2'b00, fill: 2'd0, ones: 3'd0, drop: 1'b0,
    pack: 8'h00, slot: SlotReset, skipping: 1'b1, done: 1'b0
  };

  always_comb begin
    fe_state_t  s;
    logic       line;
    logic       d;
    logic       cur;
    logic       bitv;
    logic       put;
    logic [2:0] pos;
    s     = state_q;
    entry = '{has_data: 1'b0, data: 8'h00, has_status: 1'b0, status: ST_GOOD};
    line  = 1'b0;
    d     = 1'b0;
    cur   = 1'b0;
    bitv  = 1'b0;
    put   = 1'b0;
    pos   = 3'd0;
    if (item_i.first_byte) begin
      s          = StateReset;
      s.skipping = skip_first_i;
    end
    if (!s.done) begin
      if (s.skipping) begin
        s.prev     = item_i.rx_byte[0];
        s.skipping = 1'b0;
      end else begin
        for (int i = 7; i >= 0; i--) begin
          if (!s.done) begin
            line   = item_i.rx_byte[i];
            d      = (line == s.prev);
            s.prev = line;
            put    = 1'b0;
            if (s.fill < 2'd2) begin
              s.look = {s.look[0], d};
              s.fill = s.fill + 2'd1;
            end else begin
              cur    = s.look[1];
              s.look = {s.look[0], d};
              if (s.drop) begin
                s.drop = 1'b0;
              end else begin
                put  = 1'b1;
                bitv = cur;
                if (!cur) begin
                  s.ones = 3'd0;
                end else begin
                  s.ones = s.ones + 3'd1;
                end
              end
            end
            if (put) begin
              pos         = 3'(s.slot - 4'd1);
              s.pack[pos] = bitv;
              s.slot      = s.slot - 4'd1;
              if (s.slot == 4'd0) begin
                entry.has_data = 1'b1;
                for (int k = 0; k < 8; k++) begin
                  entry.data[k] = s.pack[7-k];
                end
                s.pack = 8'h00;
                s.slot = SlotReset;
              end
              if (bitv && s.ones == OnesLimit) begin
                if (s.look[1]) begin
                  entry.has_status = 1'b1;
                  if (s.look[0]) begin
                    entry.status = ST_ABORT;
                  end else if (s.slot == GoodSlot) begin
                    entry.status = ST_GOOD;
                  end else begin
                    entry.status = ST_MISALIGNED;
                  end
                  s.done = 1'b1;
                end else begin
                  s.ones = 3'd0;
                  s.drop = 1'b1;
                end
              end
            end
          end
        end
      end
      if (item_i.last_byte && !s.done) begin
        s.done           = 1'b1;
        entry.has_status = 1'b1;
        entry.status     = ST_NO_FLAG;
      end
    end
    state_d = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

  assign push_o  = accept_i && (entry.has_data || entry.has_status);
  assign entry_o = entry;

endmodule

// ===== hw/rtl/hdlc_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_q
// Small FIFO of front-end entries decoupling front and back ends.
// ----------------------------------------------------------------------------
module hdlc_q #(
  parameter int unsigned Depth = hdlc_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  hdlc_pkg::hdlc_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output hdlc_pkg::hdlc_entry_t head_o
);
  import hdlc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  hdlc_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

endmodule

// ===== hw/rtl/hdlc_be.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_be
// Back end: expands each entry into its data and status results and holds
// them in the output register.
// ----------------------------------------------------------------------------
module hdlc_be (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  hdlc_pkg::hdlc_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hdlc_pkg::rx_result_t  out_data_o
);
  import hdlc_pkg::*;

  logic       out_valid_q, out_valid_d;
  rx_result_t out_q, out_d;
  logic       data_sent_q, data_sent_d;
  logic       load;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_d       = out_q;
    data_sent_d = data_sent_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      if (head_i.has_data && !data_sent_q) begin
        out_d = '{data_byte: head_i.data, is_status: 1'b0, status: ST_GOOD,
                  last_result: 1'b0};
        if (head_i.has_status) begin
          data_sent_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        out_d = '{data_byte: 8'h00, is_status: 1'b1, status: head_i.status,
                  last_result: 1'b1};
        data_sent_d = 1'b0;
        pop_o       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      data_sent_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      data_sent_q <= data_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/hdlc_nrzi_destuff_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_nrzi_destuff_deframer
// HDLC receive deframer: NRZI decode, zero destuffing, byte packing and
// end-of-frame status, with an APB register for opening-flag skipping.
// An accepted transaction's entry is written to the entry queue, then loaded
// into the output register. Throughput: one line byte per cycle while the queue
// is not full; a byte yielding a data byte and a status gives the data result,
// then the status result; the queue absorbs this and the input stalls when full.
// Reset: all frame state cleared, skip_first_byte = 1, output empty.
// ----------------------------------------------------------------------------
module hdlc_nrzi_destuff_deframer #(
  parameter int unsigned QueueDepth = hdlc_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hdlc_pkg::rx_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hdlc_pkg::rx_result_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import hdlc_pkg::*;

  logic        skip_first_q;
  logic        cfg_wr;
  reg_index_e  reg_idx;
  logic        accept;
  logic        push, pop, full, head_valid;
  hdlc_entry_t entry, head;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_first_q <= 1'b1;
    end else if (cfg_wr && reg_idx == REG_SKIP_FIRST) begin
      skip_first_q <= pwdata[0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SKIP_FIRST: prdata = {31'd0, skip_first_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  hdlc_fe u_fe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .skip_first_i (skip_first_q),
    .accept_i     (accept),
    .item_i       (in_data_i),
    .push_o       (push),
    .entry_o      (entry)
  );

  hdlc_q #(
    .Depth (QueueDepth)
  ) u_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head)
  );

  hdlc_be u_be (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== sim/tb_hdlc_nrzi_destuff_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_nrzi_destuff_deframer
// Self-checking bench for the HDLC NRZI decode / destuff deframer. HDLC frames
// (good, misaligned flag, abort, no closing flag) and raw noise are NRZI
// encoded and sent over the input channel. A scoreboard predicts the data
// bytes and frame status of each accepted transaction, and checks every
// output transaction in order. Both sides idle and stall at random, and
// opening-flag skipping is switched over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_hdlc_nrzi_destuff_deframer;
  import hdlc_pkg::*;

  localparam int unsigned RandomItems = 750;
  localparam int unsigned Phases      = 4;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned CycleLimit  = 800000;

  typedef enum int {
    FR_GOOD,
    FR_MISALIGN,
    FR_ABORT,
    FR_NOFLAG,
    FR_NOISE
  } frame_kind_e;

  class deframe_scoreboard;
    rx_result_t  expected_q[$];
    bit          skip_cfg;
    bit          prev_line;
    bit [1:0]    window;
    int unsigned window_fill;
    bit [2:0]    ones_run;
    bit          drop_next;
    bit [7:0]    pack_reg;
    bit [3:0]    slot;
    bit          skipping_lead;
    bit          frame_done;
    int unsigned mismatches;
    int unsigned bytes_in;
    int unsigned data_out;
    int unsigned endings[4];

    function new();
      skip_cfg = 1'b1;
      clear_frame();
    endfunction

    function void clear_frame();
      prev_line     = 1'b0;
      window        = '0;
      window_fill   = 0;
      ones_run      = '0;
      drop_next     = 1'b0;
      pack_reg      = '0;
      slot          = SlotReset;
      skipping_lead = 1'b1;
      frame_done    = 1'b0;
    endfunction

    function void expect_result(bit [7:0] data, bit is_status, frame_status_e st);
      rx_result_t r;
      r.data_byte   = data;
      r.is_status   = is_status;
      r.status      = st;
      r.last_result = is_status;
      expected_q.push_back(r);
    endfunction

    function void pack_bit(bit b);
      bit [7:0] flipped;
      pack_reg[slot - 4'd1] = b;
      slot = slot - 4'd1;
      if (slot == 4'd0) begin
        for (int i = 0; i < 8; i++) flipped[i] = pack_reg[7 - i];
        expect_result(flipped, 1'b0, ST_GOOD);
        pack_reg = '0;
        slot     = SlotReset;
      end
    endfunction

    // Two-bit lookahead: window[1] is the next bit, window[0] the one after.
    function void take_bit(bit d);
      bit cur;
      if (window_fill < 2) begin
        window = {window[0], d};
        window_fill++;
        return;
      end
      cur    = window[1];
      window = {window[0], d};
      if (drop_next) begin
        drop_next = 1'b0;
        return;
      end
      if (!cur) begin
        ones_run = '0;
        pack_bit(1'b0);
        return;
      end
      ones_run++;
      pack_bit(1'b1);
      if (ones_run == OnesLimit) begin
        if (window[1]) begin
          frame_done = 1'b1;
          if (window[0]) expect_result(8'h00, 1'b1, ST_ABORT);
          else if (slot == GoodSlot) expect_result(8'h00, 1'b1, ST_GOOD);
          else expect_result(8'h00, 1'b1, ST_MISALIGNED);
        end else begin
          ones_run  = '0;
          drop_next = 1'b1;
        end
      end
    endfunction

    function void note_input(rx_item_t it);
      bytes_in++;
      if (it.first_byte) begin
        clear_frame();
        skipping_lead = skip_cfg;
      end
      if (frame_done) return;
      if (skipping_lead) begin
        prev_line     = it.rx_byte[0];
        skipping_lead = 1'b0;
      end else begin
        for (int i = 7; i >= 0 && !frame_done; i--) begin
          take_bit(it.rx_byte[i] == prev_line);
          prev_line = it.rx_byte[i];
        end
      end
      if (it.last_byte && !frame_done) begin
        frame_done = 1'b1;
        expect_result(8'h00, 1'b1, ST_NO_FLAG);
      end
    endfunction

    task report(string what);
      $display("ERROR %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(rx_result_t got);
      rx_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
      if (got.is_status !== want.is_status)
        report($sformatf("is_status %b, expected %b", got.is_status, want.is_status));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result %b, expected %b", got.last_result, want.last_result));
      if (want.is_status) endings[want.status]++;
      else data_out++;
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  rx_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rx_result_t  out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  deframe_scoreboard sb;
  bit          dec_bits[$];
  int unsigned stuff_run;
  rx_item_t    frame_q[$];
  bit          skip_now      = 1'b1;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  int unsigned items_sent    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned cycle_count   = 0;

  hdlc_nrzi_destuff_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // Output stall: random short/long runs, plus long holds on request.
  always begin : rx_stall
    int unsigned len;
    @(posedge clk_i);
    if (holds_done < hold_requests) begin
      out_stall_i <= 1'b1;
      repeat (LongHold) @(posedge clk_i);
      holds_done++;
    end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall_i <= 1'b1;
      repeat (len - 1) @(posedge clk_i);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic rx_item_t make_item(bit [7:0] v, bit fb, bit lb);
    rx_item_t it;
    it.rx_byte    = v;
    it.first_byte = fb;
    it.last_byte  = lb;
    return it;
  endfunction

  function automatic void push_bit(bit b, bit stuffed);
    dec_bits.push_back(b);
    if (!stuffed) return;
    if (!b) begin
      stuff_run = 0;
    end else if (++stuff_run == 5) begin
      dec_bits.push_back(1'b0);
      stuff_run = 0;
    end
  endfunction

  function automatic void build_frame(frame_kind_e kind, int len);
    bit [7:0]    v;
    bit [7:0]    lead;
    bit          prev;
    bit          end_mark;
    int unsigned idx;
    int unsigned nbytes;
    int unsigned extra;
    dec_bits.delete();
    frame_q.delete();
    stuff_run = 0;
    if (kind == FR_NOISE) begin
      extra = $urandom_range(1, 5);
      for (int k = 0; k < extra; k++)
        frame_q.push_back(make_item(8'($urandom), $urandom_range(0, 3) == 0,
                                    $urandom_range(0, 4) == 0));
      return;
    end
    if (len < 0) len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0:       v = 8'hFF;
        1:       v = 8'h7E;
        2:       v = 8'h3F;
        3:       v = 8'hF8;
        default: v = 8'($urandom);
      endcase
      for (int j = 0; j < 8; j++) push_bit(v[j], 1'b1);
    end
    if (kind == FR_MISALIGN) begin
      extra = $urandom_range(1, 7);
      for (int k = 0; k < extra; k++) push_bit(1'($urandom), 1'b1);
    end
    if (kind == FR_GOOD || kind == FR_MISALIGN) begin
      v = 8'h7E;
      for (int j = 0; j < 8; j++) push_bit(v[j], 1'b0);
    end else if (kind == FR_ABORT) begin
      push_bit(1'b0, 1'b0);
      repeat (7) push_bit(1'b1, 1'b0);
    end
    while (dec_bits.size() % 8 != 0) push_bit(1'($urandom), 1'b0);
    if (!skip_now && dec_bits.size() == 0) repeat (8) push_bit(1'($urandom), 1'b0);

    nbytes   = dec_bits.size() / 8;
    end_mark = ($urandom_range(0, 9) != 0);
    if (skip_now) begin
      lead = 8'($urandom);
      frame_q.push_back(make_item(lead, 1'b1, end_mark && nbytes == 0));
      prev = lead[0];
    end else begin
      prev = 1'b0;
    end
    // NRZI: a one keeps the line level, a zero toggles it
    idx = 0;
    for (int b = 0; b < nbytes; b++) begin
      for (int j = 7; j >= 0; j--) begin
        prev = dec_bits[idx] ? prev : ~prev;
        v[j] = prev;
        idx++;
      end
      frame_q.push_back(make_item(v, !skip_now && b == 0, end_mark && b == nbytes - 1));
    end
  endfunction

  task automatic send_item(rx_item_t it, bit counted);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (tx_idle_en) begin
      r = $urandom_range(0, 99);
      if (r >= 93) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (counted) items_sent++;
  endtask

  task automatic send_frame(frame_kind_e kind, int len);
    build_frame(kind, len);
    foreach (frame_q[i]) send_item(frame_q[i], 1'b1);
    // trailing junk, normally ignored once the frame is closed
    if ($urandom_range(0, 9) == 0)
      send_item(make_item(8'($urandom), 1'b0, 1'($urandom)), 1'b0);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_skip(bit value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(REG_SKIP_FIRST));
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.skip_cfg = value;
    skip_now    = value;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(value))
      sb.report($sformatf("skip_first_byte reads %h, expected %0d", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned target;
    int unsigned r;
    bit          quiet;
    bit          paused;
    frame_kind_e kind;
    sb     = new();
    paused = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lead byte skipped even without first_byte right after reset
    send_item(make_item(8'h00, 1'b0, 1'b0), 1'b1);
    // steady line level decodes to ones: abort
    send_item(make_item(8'h00, 1'b0, 1'b0), 1'b1);
    send_item(make_item(8'hFF, 1'b0, 1'b1), 1'b1);
    // lead byte that is also the last one: no closing flag
    send_item(make_item(8'hFF, 1'b1, 1'b1), 1'b1);
    // toggling line decodes to zeros; data byte and status together
    send_item(make_item(8'h55, 1'b1, 1'b0), 1'b1);
    send_item(make_item(8'h55, 1'b0, 1'b0), 1'b1);
    send_item(make_item(8'hAA, 1'b0, 1'b1), 1'b1);
    send_frame(FR_GOOD, 1);
    send_frame(FR_MISALIGN, 2);
    send_frame(FR_ABORT, 1);
    send_frame(FR_NOFLAG, 1);
    send_frame(FR_GOOD, 0);

    for (int ph = 0; ph < Phases; ph++) begin
      wait_idle();
      write_skip(ph % 2 == 1);
      target = items_sent + RandomItems / Phases;
      while (items_sent < target) begin
        quiet      = ($urandom_range(0, 7) == 0);
        tx_idle_en = !quiet;
        rx_idle_en = !quiet;
        if (ph == 1 && hold_requests == 0 && items_sent + RandomItems / Phases / 2 >= target)
          hold_requests++;
        if (ph == 2 && !paused && items_sent + RandomItems / Phases / 2 >= target) begin
          wait_idle();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 55) kind = FR_GOOD;
        else if (r < 70) kind = FR_MISALIGN;
        else if (r < 80) kind = FR_ABORT;
        else if (r < 90) kind = FR_NOFLAG;
        else kind = FR_NOISE;
        send_frame(kind, -1);
      end
    end
    wait_idle();

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
    $display("Ran %0d line bytes with opening-flag skip on and off, %0d data bytes checked",
             sb.bytes_in, sb.data_out);
    $display("Frame endings: %0d good, %0d misaligned, %0d aborted, %0d without closing flag",
             sb.endings[ST_GOOD], sb.endings[ST_MISALIGNED], sb.endings[ST_ABORT],
             sb.endings[ST_NO_FLAG]);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
